[src/pst_pkg.sv]
// Shared types and constants for the process slot table.
// Request and response payloads, slot entry layout, operation and state codes.
// No dependencies.
package pst_pkg;

  localparam int PST_SLOTS = 128;

  localparam logic [2:0] OP_CREATE    = 3'd0;
  localparam logic [2:0] OP_FORK      = 3'd1;
  localparam logic [2:0] OP_EXIT      = 3'd2;
  localparam logic [2:0] OP_WAITPID   = 3'd3;
  localparam logic [2:0] OP_FIND_ID   = 3'd4;
  localparam logic [2:0] OP_FIND_SLOT = 3'd5;
  localparam logic [2:0] OP_SET_CUR   = 3'd6;
  // Unassigned code; the block answers it with a failed result.
  localparam logic [2:0] OP_UNDEF     = 3'd7;

  localparam logic [1:0] ST_UNUSED   = 2'd0;
  localparam logic [1:0] ST_RUNNABLE = 2'd1;
  localparam logic [1:0] ST_RUNNING  = 2'd2;
  localparam logic [1:0] ST_ZOMBIE   = 2'd3;

  localparam logic [30:0] ID_MAX = 31'h7FFF_FFFF;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] id_arg;
    logic signed [31:0] code_arg;
    logic [7:0]         slot_arg;
    logic               clear_current;
  } pst_in_t;

  typedef struct packed {
    logic               ok;
    logic [6:0]         slot_out;
    logic [30:0]        id_out;
    logic [30:0]        parent_out;
    logic [1:0]         state_out;
    logic signed [31:0] exit_status;
    logic [7:0]         live_count;
    logic               has_current;
    logic [6:0]         current_out;
  } pst_out_t;

  typedef struct packed {
    logic [1:0]  state;
    logic [30:0] id;
    logic [30:0] parent;
    logic [31:0] code;
  } pst_entry_t;

endpackage

[src/process_slot_table.sv]
// Process slot table top level: request sequencer, table scan and response register.
// Depends on pst_pkg and pst_mem.
//
//  Channel | Ports                           | Payload
//  --------+---------------------------------+-----------
//  request | in_valid, in_ready, in_data     | pst_in_t
//  result  | out_valid, out_ready, out_data  | pst_out_t
//
// Exit, set current, find by slot and requests refused before a scan go from S_CUR
// (find by slot through S_ONE) to S_OUT. Create, fork, waitpid and find by id scan
// the slot memory one entry per cycle through its single read port. After reset a
// clearing pass writes every entry, and no request is taken until it ends. A result
// waiting on out_ready does not block the next request; only its completion waits
// for the output register.
module process_slot_table #(
  parameter int TABLE_SLOTS = pst_pkg::PST_SLOTS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pst_pkg::pst_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output pst_pkg::pst_out_t out_data
);
  import pst_pkg::*;

  localparam int SW = $clog2(TABLE_SLOTS);
  localparam int CW = $clog2(TABLE_SLOTS + 1);
  localparam logic [SW-1:0] LAST_SLOT = SW'(TABLE_SLOTS - 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_CUR, S_SCAN, S_ONE, S_OUT
  } fsm_t;

  fsm_t          state_r;
  pst_in_t       req_r;
  pst_out_t      res_r;
  pst_out_t      out_r;
  logic          out_valid_r;
  logic [SW-1:0] clr_i_r;
  logic [SW:0]   scan_i_r;
  logic          pend_r;
  logic [SW-1:0] pend_addr_r;
  logic [30:0]   me_id_r;
  logic [30:0]   par_r;
  logic [30:0]   id_cnt_r;
  logic [CW-1:0] cnt_r;
  logic [SW-1:0] cur_slot_r;
  logic          cur_valid_r;

  logic          we;
  logic [SW-1:0] waddr;
  pst_entry_t    wdata;
  logic [SW-1:0] raddr;
  pst_entry_t    rdata;
  logic          usable;
  logic          match;
  logic          sarg_ok;
  logic [SW-1:0] sarg_idx;
  logic [SW+7:0] sarg_ext;
  logic [7:0]    live8;
  logic [CW+7:0] cnt_ext;

  function automatic logic [6:0] slot7(input logic [SW-1:0] s);
    logic [SW+6:0] t;
    t = {7'b0, s};
    return t[6:0];
  endfunction

  pst_mem #(.DEPTH(TABLE_SLOTS), .AW(SW)) u_mem (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign sarg_ext = {{SW{1'b0}}, req_r.slot_arg};
  assign sarg_idx = sarg_ext[SW-1:0];
  assign sarg_ok  = ({3'b0, req_r.slot_arg} < 11'(TABLE_SLOTS));
  assign cnt_ext  = {8'b0, cnt_r};
  assign live8    = cnt_ext[7:0];
  assign usable   = cur_valid_r && (rdata.state != ST_UNUSED);

  // Match test on the entry that came back from the previous scan read.
  always_comb begin
    match = 1'b0;
    unique case (req_r.op)
      OP_CREATE, OP_FORK: match = (rdata.state == ST_UNUSED);
      OP_WAITPID: match = (rdata.state == ST_ZOMBIE) && (rdata.parent == me_id_r) &&
                          ((req_r.id_arg <= 0) || (rdata.id == req_r.id_arg[30:0]));
      OP_FIND_ID: match = (rdata.state != ST_UNUSED) && !req_r.id_arg[31] &&
                          (rdata.id == req_r.id_arg[30:0]);
      default: match = 1'b0;
    endcase
  end

  // Memory address and write selection.
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = '0;
    unique case (state_r)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_i_r;
        wdata.state = (clr_i_r == '0) ? ST_RUNNING : ST_UNUSED;
        wdata.id    = (clr_i_r == '0) ? 31'd1 : 31'd0;
      end
      S_IDLE: raddr = cur_slot_r;
      S_CUR: begin
        raddr = sarg_idx;
        if (req_r.op == OP_EXIT && usable) begin
          we    = 1'b1;
          waddr = cur_slot_r;
          wdata = '{state: ST_ZOMBIE, id: rdata.id, parent: rdata.parent,
                    code: req_r.code_arg};
        end
      end
      S_SCAN: begin
        raddr = scan_i_r[SW-1:0];
        if (pend_r && match) begin
          if (req_r.op == OP_CREATE || req_r.op == OP_FORK) begin
            we    = 1'b1;
            waddr = pend_addr_r;
            wdata = '{state: ST_RUNNABLE, id: id_cnt_r, parent: par_r, code: 32'd0};
          end else if (req_r.op == OP_WAITPID) begin
            we    = 1'b1;
            waddr = pend_addr_r;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_i_r     <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      id_cnt_r    <= 31'd2;
      cnt_r       <= CW'(1);
      cur_slot_r  <= '0;
      cur_valid_r <= 1'b1;
    end else begin
      // The output register is reloaded in S_OUT, which handles its own valid.
      if (out_valid_r && out_ready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_i_r <= clr_i_r + 1'b1;
          if (clr_i_r == LAST_SLOT) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            req_r   <= in_data;
            res_r   <= '0;
            state_r <= S_CUR;
          end
        end
        S_CUR: begin
          // The current task's entry is on the read port now.
          me_id_r  <= rdata.id;
          par_r    <= usable ? rdata.id : 31'd0;
          scan_i_r <= '0;
          pend_r   <= 1'b0;
          unique case (req_r.op)
            OP_CREATE, OP_FIND_ID: state_r <= S_SCAN;
            OP_FORK, OP_WAITPID: state_r <= usable ? S_SCAN : S_OUT;
            OP_EXIT: begin
              if (usable) begin
                res_r.ok         <= 1'b1;
                res_r.slot_out   <= slot7(cur_slot_r);
                res_r.id_out     <= rdata.id;
                res_r.parent_out <= rdata.parent;
                res_r.state_out  <= ST_ZOMBIE;
              end
              state_r <= S_OUT;
            end
            OP_FIND_SLOT: state_r <= sarg_ok ? S_ONE : S_OUT;
            OP_SET_CUR: begin
              if (req_r.clear_current) begin
                cur_valid_r <= 1'b0;
                res_r.ok    <= 1'b1;
              end else if (sarg_ok) begin
                cur_slot_r  <= sarg_idx;
                cur_valid_r <= 1'b1;
                res_r.ok    <= 1'b1;
              end
              state_r <= S_OUT;
            end
            default: state_r <= S_OUT;
          endcase
        end
        S_ONE: begin
          if (rdata.state != ST_UNUSED) begin
            res_r.ok         <= 1'b1;
            res_r.slot_out   <= slot7(sarg_idx);
            res_r.id_out     <= rdata.id;
            res_r.parent_out <= rdata.parent;
            res_r.state_out  <= rdata.state;
          end
          state_r <= S_OUT;
        end
        S_SCAN: begin
          scan_i_r    <= scan_i_r + 1'b1;
          pend_r      <= (scan_i_r < (SW+1)'(TABLE_SLOTS));
          pend_addr_r <= scan_i_r[SW-1:0];
          if (pend_r && match) begin
            res_r.ok       <= 1'b1;
            res_r.slot_out <= slot7(pend_addr_r);
            if (req_r.op == OP_CREATE || req_r.op == OP_FORK) begin
              res_r.id_out     <= id_cnt_r;
              res_r.parent_out <= par_r;
              res_r.state_out  <= ST_RUNNABLE;
              cnt_r            <= cnt_r + 1'b1;
              id_cnt_r         <= (id_cnt_r >= ID_MAX) ? 31'd1 : id_cnt_r + 1'b1;
            end else begin
              res_r.id_out     <= rdata.id;
              res_r.parent_out <= rdata.parent;
              if (req_r.op == OP_WAITPID) begin
                res_r.state_out   <= ST_UNUSED;
                res_r.exit_status <= rdata.code;
                if (cnt_r != '0) begin
                  cnt_r <= cnt_r - 1'b1;
                end
              end else begin
                res_r.state_out <= rdata.state;
              end
            end
            state_r <= S_OUT;
          end else if (pend_r && pend_addr_r == LAST_SLOT) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_r <= {res_r.ok, res_r.slot_out, res_r.id_out, res_r.parent_out,
                      res_r.state_out, res_r.exit_status, live8, cur_valid_r,
                      slot7(cur_slot_r)};
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // The occupied count can never exceed the table size.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(TABLE_SLOTS))
    else $error("occupied count above table size");

  // An accepted request keeps the sequencer busy in the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  // Table state does not change while the sequencer idles.
  a_idle_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) && !in_valid |=> $stable(cnt_r) && $stable(id_cnt_r))
    else $error("state changed while idle");

endmodule

[src/pst_mem.sv]
// Slot entry memory: one write port, one read port, registered read data.
// Depends on pst_pkg for the entry layout.
module pst_mem #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  pst_pkg::pst_entry_t wdata,
  input  logic [AW-1:0]       raddr,
  output pst_pkg::pst_entry_t rdata
);
  import pst_pkg::*;

  pst_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
